// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk with an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define SCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define SCI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sci_pkg.sv =====
package sci_pkg;
  localparam int unsigned MAX_BINS_DEF = 256;
  localparam int unsigned LEVEL_W      = 17;
  localparam int unsigned WEIGHT_W     = 32;
  localparam int unsigned SUM_W        = 40;
  localparam int unsigned EDGE_W       = 9;
  localparam int unsigned FRAC_W       = 16;
  localparam int unsigned PROD_W       = LEVEL_W + SUM_W;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 17'd62259;
  localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
endpackage

// ===== hw/rtl/sci_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle.
module sci_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sci_pkg::LEVEL_W-1:0]   a,
  input  logic [sci_pkg::SUM_W-1:0]     b,
  output logic                          done,
  output logic [sci_pkg::PROD_W-1:0]    prod
);
  import sci_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [LEVEL_W-1:0]  a_r;
  logic [PROD_W-1:0]   b_r;
  logic [PROD_W-1:0]   acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        a_r    <= a;
        b_r    <= PROD_W'(b);
        acc_r  <= '0;
      end else if (busy_r) begin
        if (a_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          // add the shifted multiplicand for each set bit
          if (a_r[0]) acc_r <= acc_r + b_r;
          a_r <= a_r >> 1;
          b_r <= b_r << 1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

// ===== hw/rtl/shortest_credible_interval.sv =====
// Loads one bin per cycle while not busy; the item marked last starts the interval search.
// After the last item the level multiply runs, then the bin memory is scanned
// through its single read port once per ranked bin taken, plus one final pass.
// Result appears on out_valid for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears control state and sets the level.
`include "assert_macros.svh"
module shortest_credible_interval #(
  parameter int unsigned MAX_BINS = sci_pkg::MAX_BINS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [sci_pkg::LEVEL_W-1:0]    cfg_wr_data,
  input  logic                           start,
  output logic                           busy,
  input  logic [sci_pkg::WEIGHT_W-1:0]   in_bin_weight,
  input  logic                           in_last_bin,
  output logic                           out_valid,
  output logic [sci_pkg::EDGE_W-1:0]     out_lower_edge,
  output logic [sci_pkg::EDGE_W-1:0]     out_upper_edge,
  output logic                           out_interval_valid,
  output logic [sci_pkg::SUM_W-1:0]      out_covered_weight,
  output logic [sci_pkg::SUM_W-1:0]      out_total_weight,
  output logic                           out_truncated
);
  import sci_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BINS);
  localparam int unsigned CW = $clog2(MAX_BINS + 1);
  localparam int unsigned XW = (CW > EDGE_W) ? CW : EDGE_W;

  typedef enum logic [2:0] {S_LOAD, S_MUL, S_SCAN, S_EVAL} state_t;

  state_t              state_r;
  logic [LEVEL_W-1:0]  level_r;
  logic [CW-1:0]       count_r;
  logic [SUM_W-1:0]    total_r;
  logic                ovf_r;
  logic                mul_start_r;
  logic                mul_done;
  logic [PROD_W-1:0]   mul_prod;
  logic [PROD_W-1:0]   limit_r;
  logic [CW-1:0]       scan_r;
  logic                rd_vld_r;
  logic [AW-1:0]       rd_idx_r;
  logic [WEIGHT_W-1:0] rd_data_r;
  logic                have_prev_r;
  logic [WEIGHT_W-1:0] prev_w_r;
  logic [AW-1:0]       prev_idx_r;
  logic                best_vld_r;
  logic [WEIGHT_W-1:0] best_w_r;
  logic [AW-1:0]       best_idx_r;
  logic [SUM_W-1:0]    sum_r;
  logic [CW-1:0]       lower_r;
  logic [CW-1:0]       upper_r;
  logic                out_valid_r;
  logic [EDGE_W-1:0]   out_lower_r;
  logic [EDGE_W-1:0]   out_upper_r;
  logic                out_ivld_r;
  logic [SUM_W-1:0]    out_cov_r;
  logic [SUM_W-1:0]    out_tot_r;
  logic                out_trunc_r;

  logic [WEIGHT_W-1:0] bin_mem [MAX_BINS];

  logic                accept;
  logic                room;
  logic [SUM_W:0]      total_sum;
  logic [SUM_W-1:0]    total_nxt;
  logic                eligible;
  logic                better;
  logic [SUM_W:0]      next_sum;
  logic                take;
  logic [CW-1:0]       best_idx_x;
  logic [CW-1:0]       best_top;
  logic [XW-1:0]       lower_x;
  logic [XW-1:0]       upper_x;

  assign accept    = start && (state_r == S_LOAD);
  assign room      = (count_r < CW'(MAX_BINS));
  assign total_sum = {1'b0, total_r} + (SUM_W+1)'(in_bin_weight);
  assign total_nxt = total_sum[SUM_W] ? SUM_MAX : total_sum[SUM_W-1:0];

  // ranking compare: after the previous pick and ahead of the current best
  assign eligible = !have_prev_r || (rd_data_r < prev_w_r) ||
                    ((rd_data_r == prev_w_r) && (rd_idx_r > prev_idx_r));
  assign better   = !best_vld_r || (rd_data_r > best_w_r);

  // threshold test: (sum + w) * 2^16 > level * total
  assign next_sum   = {1'b0, sum_r} + (SUM_W+1)'(best_w_r);
  assign take       = best_vld_r &&
                      !({next_sum[SUM_W-1:0], {FRAC_W{1'b0}}} > limit_r);
  assign best_idx_x = CW'(best_idx_r);
  assign best_top   = best_idx_x + CW'(1);
  assign lower_x    = XW'(lower_r);
  assign upper_x    = XW'(upper_r);

  sci_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (level_r),
    .b     (total_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // bin memory: write on load, registered read during scans
  always_ff @(posedge clk) begin
    if (accept && room) bin_mem[count_r[AW-1:0]] <= in_bin_weight;
    rd_data_r <= bin_mem[scan_r[AW-1:0]];
    rd_idx_r  <= scan_r[AW-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      level_r     <= LEVEL_RESET;
      count_r     <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      mul_start_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
    end else begin
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      if (cfg_wr_en) level_r <= cfg_wr_data;
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              count_r <= count_r + CW'(1);
              total_r <= total_nxt;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_last_bin) begin
              mul_start_r <= 1'b1;
              state_r     <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            limit_r     <= mul_prod;
            have_prev_r <= 1'b0;
            best_vld_r  <= 1'b0;
            sum_r       <= '0;
            lower_r     <= count_r;
            upper_r     <= '0;
            scan_r      <= '0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue reads over all stored bins
          if (scan_r < count_r) begin
            scan_r   <= scan_r + CW'(1);
            rd_vld_r <= 1'b1;
          end else if (!rd_vld_r) begin
            state_r <= S_EVAL;
          end
          if (rd_vld_r && eligible && better) begin
            best_vld_r <= 1'b1;
            best_w_r   <= rd_data_r;
            best_idx_r <= rd_idx_r;
          end
        end
        S_EVAL: begin
          if (take) begin
            sum_r       <= next_sum[SUM_W-1:0];
            if (best_idx_x < lower_r) lower_r <= best_idx_x;
            if (best_top > upper_r) upper_r <= best_top;
            have_prev_r <= 1'b1;
            prev_w_r    <= best_w_r;
            prev_idx_r  <= best_idx_r;
            best_vld_r  <= 1'b0;
            scan_r      <= '0;
            state_r     <= S_SCAN;
          end else begin
            out_valid_r <= 1'b1;
            out_lower_r <= lower_x[EDGE_W-1:0];
            out_upper_r <= upper_x[EDGE_W-1:0];
            out_ivld_r  <= (lower_r < upper_r);
            out_cov_r   <= sum_r;
            out_tot_r   <= total_r;
            out_trunc_r <= ovf_r;
            count_r     <= '0;
            total_r     <= '0;
            ovf_r       <= 1'b0;
            scan_r      <= '0;
            state_r     <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign busy               = (state_r != S_LOAD);
  assign out_valid          = out_valid_r;
  assign out_lower_edge     = out_lower_r;
  assign out_upper_edge     = out_upper_r;
  assign out_interval_valid = out_ivld_r;
  assign out_covered_weight = out_cov_r;
  assign out_total_weight   = out_tot_r;
  assign out_truncated      = out_trunc_r;

  `SCI_ASSERT(a_cover_le_total, out_valid |-> (out_covered_weight <= out_total_weight), "covered weight exceeds total")
  `SCI_ASSERT(a_idle_after_out, out_valid |-> !busy, "block still busy after result")
  `SCI_ASSERT(a_count_bound, (count_r <= CW'(MAX_BINS)), "bin count beyond capacity")
  `SCI_ASSERT_ALWAYS(a_out_pulse, out_valid |=> !out_valid, "result strobe longer than one cycle")
endmodule

// ===== tb/tb_shortest_credible_interval.sv =====
module tb_shortest_credible_interval;
  import sci_pkg::*;

  localparam int CAPACITY = MAX_BINS_DEF;

  typedef struct packed {
    logic [EDGE_W-1:0] lower;
    logic [EDGE_W-1:0] upper;
    logic              ivalid;
    logic [SUM_W-1:0]  covered;
    logic [SUM_W-1:0]  total;
    logic              trunc;
  } interval_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [LEVEL_W-1:0]  cfg_wr_data;
  logic                start;
  logic                busy;
  logic [WEIGHT_W-1:0] in_bin_weight;
  logic                in_last_bin;
  logic                out_valid;
  logic [EDGE_W-1:0]   out_lower_edge;
  logic [EDGE_W-1:0]   out_upper_edge;
  logic                out_interval_valid;
  logic [SUM_W-1:0]    out_covered_weight;
  logic [SUM_W-1:0]    out_total_weight;
  logic                out_truncated;

  shortest_credible_interval dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .start, .busy,
    .in_bin_weight, .in_last_bin, .out_valid, .out_lower_edge,
    .out_upper_edge, .out_interval_valid, .out_covered_weight,
    .out_total_weight, .out_truncated
  );

  // Model state: current histogram and level
  logic [WEIGHT_W-1:0] hist_bins[$];
  logic [SUM_W-1:0]    hist_total;
  logic                hist_over;
  logic [LEVEL_W-1:0]  level_now;
  interval_t           pending_intervals[$];

  int errors;
  int items_sent;
  int intervals_seen;
  int empty_intervals;
  int truncated_seen;
  int idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("shortest_credible_interval regression: fail");
    $finish;
  end

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    errors++;
  endtask

  // Rank bins heaviest first (stable), take them while taken * 2^16 <= level * total
  function automatic interval_t close_histogram();
    interval_t r;
    int order[CAPACITY];
    int n, i, j, idx;
    logic [63:0] limit, taken, next;
    int lo, hi;
    n = hist_bins.size();
    for (i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && hist_bins[order[j-1]] < hist_bins[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    limit = 64'(level_now) * 64'(hist_total);
    taken = '0;
    lo = n;
    hi = 0;
    for (i = 0; i < n; i++) begin
      idx = order[i];
      next = taken + 64'(hist_bins[idx]);
      if ((next << 16) > limit) break;
      taken = next;
      if (idx < lo) lo = idx;
      if (idx + 1 > hi) hi = idx + 1;
    end
    r.lower   = lo[EDGE_W-1:0];
    r.upper   = hi[EDGE_W-1:0];
    r.ivalid  = (lo < hi);
    r.covered = taken[SUM_W-1:0];
    r.total   = hist_total;
    r.trunc   = hist_over;
    return r;
  endfunction

  function automatic void load_bin(logic [WEIGHT_W-1:0] w, logic last);
    logic [SUM_W:0] s;
    if (hist_bins.size() < CAPACITY) begin
      hist_bins.push_back(w);
      s = {1'b0, hist_total} + (SUM_W+1)'(w);
      hist_total = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    end else begin
      hist_over = 1'b1;
    end
    if (last) begin
      pending_intervals.push_back(close_histogram());
      hist_bins.delete();
      hist_total = '0;
      hist_over = 1'b0;
    end
  endfunction

  // Result checker
  initial begin
    interval_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid) begin
        if (pending_intervals.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pending_intervals.pop_front();
          intervals_seen++;
          if (!want.ivalid) empty_intervals++;
          if (want.trunc) truncated_seen++;
          if (out_lower_edge !== want.lower)
            report_mismatch("lower_edge", out_lower_edge, want.lower);
          if (out_upper_edge !== want.upper)
            report_mismatch("upper_edge", out_upper_edge, want.upper);
          if (out_interval_valid !== want.ivalid)
            report_mismatch("interval_valid", out_interval_valid, want.ivalid);
          if (out_covered_weight !== want.covered)
            report_mismatch("covered_weight", out_covered_weight, want.covered);
          if (out_total_weight !== want.total)
            report_mismatch("total_weight", out_total_weight, want.total);
          if (out_truncated !== want.trunc)
            report_mismatch("truncated", out_truncated, want.trunc);
        end
      end
    end
  end

  // Drive one bin; returns once the block has taken it
  task automatic send_bin(logic [WEIGHT_W-1:0] w, logic last);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_bin_weight = w;
    in_last_bin = last;
    do @(posedge clk); while (busy);
    load_bin(w, last);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_intervals.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_level(logic [LEVEL_W-1:0] v);
    wait_drained();
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    level_now = v;
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return WEIGHT_W'($urandom_range(15));
      3: return $urandom();
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  task automatic send_histogram(int n);
    for (int i = 0; i < n; i++) send_bin(pick_weight(), i == n - 1);
  endtask

  // Corner histograms at a few levels
  task automatic test_directed();
    send_bin('1, 1'b1);
    send_bin(32'd5, 1'b0);
    send_bin(32'd5, 1'b1);
    send_bin('0, 1'b0);
    send_bin('0, 1'b0);
    send_bin('0, 1'b1);
    send_bin(32'd1, 1'b0);
    send_bin('1, 1'b0);
    send_bin(32'd2, 1'b0);
    send_bin('1, 1'b1);
    set_level('0);
    send_bin(32'd7, 1'b0);
    send_bin(32'd3, 1'b1);
    send_bin('0, 1'b0);
    send_bin('0, 1'b1);
    set_level(LEVEL_W'(65536));
    send_bin(32'd9, 1'b0);
    send_bin(32'h8000_0000, 1'b0);
    send_bin(32'd9, 1'b1);
    set_level('1);
    send_bin(32'd4, 1'b0);
    send_bin(32'd100, 1'b1);
    set_level(LEVEL_W'(32768));
    send_bin(32'd10, 1'b0);
    send_bin(32'd1, 1'b0);
    send_bin(32'd10, 1'b1);
  endtask

  // Full store, then more bins than it holds
  task automatic test_capacity();
    set_level(LEVEL_W'(65536));
    send_histogram(CAPACITY);
    set_level(LEVEL_RESET);
    send_histogram(CAPACITY + 3);
  endtask

  task automatic test_random();
    int pcts[3] = '{0, 83, 32};
    int budget;
    for (int p = 0; p < 3; p++) begin
      set_level(p == 1 ? LEVEL_W'($urandom_range(65536)) : LEVEL_W'($urandom()));
      idle_pct = pcts[p];
      budget = 0;
      while (budget < 90) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 10);
        send_histogram(n);
        budget += n;
        // hold off once per phase until everything is back
        if (budget > 45 && budget - n <= 45) wait_drained();
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    intervals_seen = 0;
    empty_intervals = 0;
    truncated_seen = 0;
    idle_pct = 0;
    hist_total = '0;
    hist_over = 1'b0;
    level_now = LEVEL_RESET;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    start = 1'b0;
    in_bin_weight = '0;
    in_last_bin = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_capacity();
    test_random();

    wait_drained();
    $display("covered %0d bins in %0d histograms (%0d empty intervals, %0d truncated)",
             items_sent, intervals_seen, empty_intervals, truncated_seen);
    $display("levels swept from zero past one, sender idling at 0/83/32 percent");
    if (errors == 0) begin
      $display("shortest_credible_interval regression: pass");
    end else begin
      $display("shortest_credible_interval regression: fail");
    end
    $finish;
  end
endmodule
